// ----- rtl/core/tx_rrbs_pkg.sv -----
// Shared types and constants of the round-robin byte scheduler.
`timescale 1ns / 1ps
`default_nettype none

package tx_rrbs_pkg;

	// Command codes of an input item.
	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_QUANTUM  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SIZE = 2'd2;

	localparam int SIZE_W   = 16;
	localparam int BUDGET_W = 20;
	localparam int ID_W     = 8;

	localparam logic [SIZE_W-1:0]   QUANTUM_RESET  = 16'd256;
	localparam logic [BUDGET_W-1:0] PERIOD_RESET   = 20'd4096;
	localparam logic [SIZE_W-1:0]   MIN_SIZE_RESET = 16'd128;

	// Completions reported for one input item at most.
	localparam int MAX_RESULTS  = 16;
	localparam int RESULT_CNT_W = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic              command;
		logic [SIZE_W-1:0] packet_size;
		logic [ID_W-1:0]   packet_tag;
		logic [ID_W-1:0]   dest_id;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0] done_tag;
		logic [ID_W-1:0] done_dest;
		logic            rejected;
		logic            last;
	} out_item_t;

	typedef struct packed {
		logic [SIZE_W-1:0] remaining;
		logic [ID_W-1:0]   tag;
		logic [ID_W-1:0]   dest;
	} entry_t;

	typedef struct packed {
		logic [SIZE_W-1:0]   new_remaining;
		logic [BUDGET_W-1:0] new_budget;
		logic                entry_done;
		logic                budget_empty;
	} slice_t;

endpackage

`default_nettype wire

// ----- rtl/core/tx_rrbs_slice.sv -----
// Slice arithmetic: grants min(quantum, remaining, budget) and charges it.
`timescale 1ns / 1ps
`default_nettype none

module tx_rrbs_slice (
	input  wire logic [tx_rrbs_pkg::SIZE_W-1:0]   quantum,
	input  wire logic [tx_rrbs_pkg::SIZE_W-1:0]   remaining,
	input  wire logic [tx_rrbs_pkg::BUDGET_W-1:0] budget,
	output tx_rrbs_pkg::slice_t                   result
);
	import tx_rrbs_pkg::*;

	logic [SIZE_W-1:0]   qr_min;
	logic [BUDGET_W-1:0] qr_ext;
	logic [BUDGET_W-1:0] grant;

	always_comb begin
		qr_min = (quantum < remaining) ? quantum : remaining;
		qr_ext = {{(BUDGET_W-SIZE_W){1'b0}}, qr_min};
		grant  = (qr_ext < budget) ? qr_ext : budget;
		result.new_remaining = remaining - grant[SIZE_W-1:0];
		result.new_budget    = budget - grant;
		result.entry_done    = (result.new_remaining == '0);
		result.budget_empty  = (result.new_budget == '0);
	end

endmodule

`default_nettype wire

// ----- rtl/core/tx_round_robin_byte_scheduler.sv -----
// Top level of the byte-budget round-robin transmit scheduler.
// An enqueue that finds the block active and the queue not full, or a tick on an empty queue,
// starts no pass. A service pass runs from the transfer through a start in CHECK, one SERVE
// step per slice, and after each completion one SHIFT step per later entry that closes up
// and a restart in CHECK; FLUSH ends it. The block takes no new item while a pass runs,
// as in_ready is high only in IDLE.
// Reset: queue empty, pointer zero, budget and registers at their defaults, block idle.
`timescale 1ns / 1ps
`default_nettype none

module tx_round_robin_byte_scheduler #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output      logic                                in_ready,
	input  wire tx_rrbs_pkg::in_item_t               in_data,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      tx_rrbs_pkg::out_item_t              out_data,
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic [tx_rrbs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tx_rrbs_pkg::BUDGET_W-1:0]    cfg_data
);
	import tx_rrbs_pkg::*;

	// Pointer width and count width; the count holds the depth itself.
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = PW + 1;

	// Controller states.
	localparam logic [2:0] ST_IDLE  = 3'd0; // waiting for an input item
	localparam logic [2:0] ST_CHECK = 3'd1; // loop head of a pass, issues the first read
	localparam logic [2:0] ST_SERVE = 3'd2; // one slice per cycle unless a completion stalls on the output
	localparam logic [2:0] ST_SHIFT = 3'd3; // closes the gap behind a completed entry
	localparam logic [2:0] ST_FLUSH = 3'd4; // hands over the final result, if any, with last set

	// Entry memory: one write and one registered read per cycle.
	entry_t mem [QUEUE_DEPTH];
	entry_t rd_q;
	logic   mem_we;
	logic   mem_re;
	logic [PW-1:0] mem_waddr;
	logic [PW-1:0] mem_raddr;
	entry_t mem_wdata;

	// Control and configuration state.
	logic [2:0]              state_q, state_d;
	logic [CW-1:0]           count_q, count_d;
	logic [PW-1:0]           ptr_q, ptr_d;
	logic [PW-1:0]           cur_q, cur_d;
	logic [PW-1:0]           shift_q, shift_d;
	logic [CW-1:0]           slices_q, slices_d;
	logic [RESULT_CNT_W-1:0] nres_q, nres_d;
	logic [BUDGET_W-1:0]     budget_q, budget_d;
	logic                    active_q, active_d;
	logic [SIZE_W-1:0]       quantum_q;
	logic [BUDGET_W-1:0]     period_q;
	logic [SIZE_W-1:0]       min_size_q;

	// The newest result is held back until it is known whether it is the last one.
	logic      pend_valid_q, pend_valid_d;
	out_item_t pend_q, pend_d;
	logic      out_valid_q;
	out_item_t out_q;
	logic      push;
	out_item_t push_data;

	// Forwarding covers a read of the entry that is being written in the same cycle.
	logic   fwd_q, fwd_d;
	entry_t fwd_data_q, fwd_data_d;

	entry_t  cur_entry;
	slice_t  sl;
	logic    out_free;
	logic    in_xfer;
	logic    stall;
	logic [CW-1:0] cur_next;
	logic [PW-1:0] ptr_wrap;
	logic [PW-1:0] chk_ptr;
	logic    pass_go;
	logic    keep_going;
	logic [SIZE_W-1:0] padded_size;

	assign cur_entry = fwd_q ? fwd_data_q : rd_q;
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign padded_size = (in_data.packet_size < min_size_q) ? min_size_q : in_data.packet_size;
	assign cur_next    = {1'b0, cur_q} + CW'(1);
	assign ptr_wrap    = (cur_next >= count_q) ? '0 : cur_next[PW-1:0];
	assign chk_ptr     = ({1'b0, ptr_q} >= count_q) ? '0 : ptr_q;
	assign pass_go     = (budget_q != '0) && (count_q != '0) &&
	                     (slices_q != CW'(QUEUE_DEPTH)) && (nres_q != RESULT_CNT_W'(MAX_RESULTS));

	tx_rrbs_slice u_slice (
		.quantum   (quantum_q),
		.remaining (cur_entry.remaining),
		.budget    (budget_q),
		.result    (sl)
	);

	// A completion can only be recorded when the held result has somewhere to go.
	assign stall = (state_q == ST_SERVE) && sl.entry_done && pend_valid_q && !out_free;
	assign keep_going = !sl.budget_empty && ((slices_q + CW'(1)) != CW'(QUEUE_DEPTH));

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		ptr_d        = ptr_q;
		cur_d        = cur_q;
		shift_d      = shift_q;
		slices_d     = slices_q;
		nres_d       = nres_q;
		budget_d     = budget_q;
		active_d     = active_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		fwd_d        = fwd_q;
		fwd_data_d   = fwd_data_q;
		push         = 1'b0;
		push_data    = pend_q;
		mem_we       = 1'b0;
		mem_waddr    = cur_q;
		mem_wdata    = cur_entry;
		mem_re       = 1'b0;
		mem_raddr    = cur_q;

		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (in_data.command == CMD_ENQUEUE) begin
						if (count_q == CW'(QUEUE_DEPTH)) begin
							// Queue full: the refusal is the only result of this item.
							pend_d.done_tag  = in_data.packet_tag;
							pend_d.done_dest = in_data.dest_id;
							pend_d.rejected  = 1'b1;
							pend_d.last      = 1'b0;
							pend_valid_d     = 1'b1;
							state_d          = ST_FLUSH;
						end else begin
							mem_we          = 1'b1;
							mem_waddr       = count_q[PW-1:0];
							mem_wdata.remaining = padded_size;
							mem_wdata.tag   = in_data.packet_tag;
							mem_wdata.dest  = in_data.dest_id;
							count_d         = count_q + CW'(1);
							if (!active_q) begin
								active_d = 1'b1;
								slices_d = '0;
								nres_d   = '0;
								state_d  = ST_CHECK;
							end
						end
					end else begin
						budget_d = period_q;
						if (count_q == '0) begin
							active_d = 1'b0;
						end else begin
							active_d = 1'b1;
							slices_d = '0;
							nres_d   = '0;
							state_d  = ST_CHECK;
						end
					end
				end
			end
			ST_CHECK: begin
				if (pass_go) begin
					mem_re    = 1'b1;
					mem_raddr = chk_ptr;
					fwd_d     = 1'b0;
					cur_d     = chk_ptr;
					state_d   = ST_SERVE;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_SERVE: begin
				if (!stall) begin
					budget_d = sl.new_budget;
					slices_d = slices_q + CW'(1);
					if (sl.entry_done) begin
						if (pend_valid_q) begin
							push      = 1'b1;
							push_data = pend_q;
						end
						pend_d.done_tag  = cur_entry.tag;
						pend_d.done_dest = cur_entry.dest;
						pend_d.rejected  = 1'b0;
						pend_d.last      = 1'b0;
						pend_valid_d     = 1'b1;
						nres_d           = nres_q + RESULT_CNT_W'(1);
						if (cur_next < count_q) begin
							// Later entries move down one slot, starting right behind this one.
							mem_re    = 1'b1;
							mem_raddr = cur_next[PW-1:0];
							fwd_d     = 1'b0;
							shift_d   = cur_q;
							state_d   = ST_SHIFT;
						end else begin
							// The last entry left: the pointer wraps to the head.
							count_d = count_q - CW'(1);
							ptr_d   = '0;
							state_d = ST_CHECK;
						end
					end else begin
						mem_we              = 1'b1;
						mem_waddr           = cur_q;
						mem_wdata.remaining = sl.new_remaining;
						ptr_d               = ptr_wrap;
						if (keep_going) begin
							mem_re     = 1'b1;
							mem_raddr  = ptr_wrap;
							fwd_d      = (ptr_wrap == cur_q);
							fwd_data_d = mem_wdata;
							cur_d      = ptr_wrap;
						end else begin
							state_d = ST_FLUSH;
						end
					end
				end
			end
			ST_SHIFT: begin
				mem_we    = 1'b1;
				mem_waddr = shift_q;
				mem_wdata = rd_q;
				if (({1'b0, shift_q} + CW'(2)) < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = shift_q + PW'(2);
					fwd_d     = 1'b0;
					shift_d   = shift_q + PW'(1);
				end else begin
					// The pointer keeps its slot, which now holds the next entry.
					count_d = count_q - CW'(1);
					ptr_d   = cur_q;
					state_d = ST_CHECK;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					push           = 1'b1;
					push_data      = pend_q;
					push_data.last = 1'b1;
					pend_valid_d   = 1'b0;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		cur_q      <= cur_d;
		shift_q    <= shift_d;
		pend_q     <= pend_d;
		fwd_data_q <= fwd_data_d;
		if (push) begin
			out_q <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			ptr_q        <= '0;
			slices_q     <= '0;
			nres_q       <= '0;
			budget_q     <= PERIOD_RESET;
			active_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			fwd_q        <= 1'b0;
			quantum_q    <= QUANTUM_RESET;
			period_q     <= PERIOD_RESET;
			min_size_q   <= MIN_SIZE_RESET;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			ptr_q        <= ptr_d;
			slices_q     <= slices_d;
			nres_q       <= nres_d;
			budget_q     <= budget_d;
			active_q     <= active_d;
			pend_valid_q <= pend_valid_d;
			fwd_q        <= fwd_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// Register writes are for the user to make only while the block is idle; the block does not enforce it.
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_QUANTUM:  quantum_q  <= cfg_data[SIZE_W-1:0];
					CFG_PERIOD:   period_q   <= cfg_data;
					CFG_MIN_SIZE: min_size_q <= cfg_data[SIZE_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire
